FILE: design/swm_pkg.sv
// Shared types and constants of the sliding window maximum filter.
`timescale 1ns / 1ps

package swm_pkg;

   localparam int WINDOW_MAX = 64;
   localparam int IDX_W      = $clog2(WINDOW_MAX);
   localparam int AGE_W      = $clog2(WINDOW_MAX + 1);
   localparam int WSIZE_W    = 7;
   localparam int SAMPLE_W   = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;

   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_DROP = 2'd1,
      CELL_STEP = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type                 op;
      logic                        restart;
      logic                        shift_one;
      logic signed [SAMPLE_W-1:0]  sample;
      logic [WSIZE_W-1:0]          window;
   } cell_ctrl_type;

   typedef struct packed {
      logic                        live;
      logic signed [SAMPLE_W-1:0]  value;
      logic [AGE_W-1:0]            age;
   } cell_link_type;

endpackage

FILE: design/swm_cell.sv
// One candidate slot of the monotonic queue, linked to its two neighbors.
`timescale 1ns / 1ps

module swm_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  swm_pkg::cell_ctrl_type        ctrl,
   input  logic [swm_pkg::IDX_W-1:0]     position,
   input  swm_pkg::cell_link_type        next_link,
   input  logic                          prev_keep,
   output swm_pkg::cell_link_type        link,
   output logic                          stale,
   output logic                          keep,
   output logic signed [swm_pkg::SAMPLE_W-1:0] front_value,
   output logic                          valid,
   output logic [swm_pkg::AGE_W-1:0]     age
);
   import swm_pkg::*;

   logic                       valid_ff, valid_in;
   logic signed [SAMPLE_W-1:0] value_ff, value_in;
   logic [AGE_W-1:0]           age_ff, age_in;
   logic                       in_window;
   logic                       src_live;
   logic signed [SAMPLE_W-1:0] src_value;
   logic [AGE_W-1:0]           src_age;
   logic                       take_new;

   // A slot counts only if no restart is pending and it lies inside the window.
   assign in_window = ({1'b0, position} < ctrl.window);
   assign link.live  = valid_ff && !ctrl.restart && in_window;
   assign link.value = value_ff;
   assign link.age   = age_ff;

   assign stale = link.live && ({1'b0, age_ff} + 1'b1 >= {1'b0, ctrl.window});

   always_comb begin
      if (ctrl.shift_one) begin
         src_live  = next_link.live;
         src_value = next_link.value;
         src_age   = next_link.age;
      end else begin
         src_live  = link.live;
         src_value = value_ff;
         src_age   = age_ff;
      end
   end

   // Candidates not below the new sample stay; the first free slot takes it.
   assign keep     = src_live && !(src_value < ctrl.sample);
   assign take_new = !keep && prev_keep;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      age_in   = age_ff;
      case (ctrl.op)
         CELL_DROP: begin
            valid_in = next_link.live;
            value_in = next_link.value;
            age_in   = next_link.age;
         end
         CELL_STEP: begin
            valid_in = keep || take_new;
            value_in = keep ? src_value : ctrl.sample;
            age_in   = keep ? AGE_W'(src_age + 1'b1) : '0;
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   assign front_value = value_in;
   assign valid       = valid_ff;
   assign age         = age_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      age_ff   <= age_in;
   end

endmodule

FILE: design/swm_csr.sv
// Register port holding the window size setting.
`timescale 1ns / 1ps

module swm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [swm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [swm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [swm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output logic [swm_pkg::WSIZE_W-1:0]      window_size
);
   import swm_pkg::*;

   logic [WSIZE_W-1:0]   window_size_ff, window_size_in;
   logic [CSR_IDX_W-1:0] reg_index;
   logic                 write_en;

   assign reg_index = csr_paddr[CSR_ADDR_W-1:2];
   assign write_en  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      window_size_in = window_size_ff;
      if (write_en && reg_index == REG_WINDOW_SIZE) begin
         window_size_in = csr_pwdata[WSIZE_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (reg_index)
         REG_WINDOW_SIZE: csr_prdata = CSR_DATA_W'(window_size_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WSIZE_W'(1);
      end else begin
         window_size_ff <= window_size_in;
      end
   end

   assign window_size = window_size_ff;

endmodule

FILE: design/sliding_window_maximum.sv
// Top level of the sliding window maximum filter.
//
//   Channel   Direction   Handshake                 Payload
//   req       in          req_valid / req_ready     req_sample, req_restart
//   rsp       out         rsp_valid / rsp_ready     rsp_window_max
//   csr       in/out      csr_psel/penable/pready   csr_paddr, csr_pwdata, csr_prdata
//
// One transaction per cycle unless a held result or stale retirement stalls it: each cell
// ages, evicts and shifts by at most one place per cycle, so an item waits while each stale
// candidate beyond the first is retired, which only happens after the window shrinks.
// Reset is synchronous: the queue empties and the window size returns to 1.
// A result waits in the output register while rsp_ready is low; the next request is taken
// into the item register meanwhile and processed once the output slot frees up.
`timescale 1ns / 1ps

module sliding_window_maximum (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [swm_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [swm_pkg::SAMPLE_W-1:0]  rsp_window_max,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [swm_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [swm_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [swm_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import swm_pkg::*;

   logic [WSIZE_W-1:0]         window_size;
   logic [WSIZE_W-1:0]         window_eff;

   logic                       busy_ff, busy_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                       restart_ff, restart_in;
   logic [WSIZE_W-1:0]         seen_ff, seen_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_max_ff, rsp_max_in;

   logic [WSIZE_W-1:0]         seen_clamped;
   logic [WSIZE_W-1:0]         seen_next;
   logic                       has_result;
   logic                       out_free;
   logic                       double_stale;
   logic                       fire_step;
   logic                       fire_drop;
   logic                       req_fire;

   cell_ctrl_type              ctrl;
   cell_link_type              links [WINDOW_MAX+1];
   logic                       stale [WINDOW_MAX];
   logic                       keeps [WINDOW_MAX+1];
   logic signed [SAMPLE_W-1:0] front_values [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]      valid_vec;
   logic [AGE_W-1:0]           ages [WINDOW_MAX];

   swm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .window_size (window_size)
   );

   // A zero window acts as one; anything above the queue depth saturates.
   always_comb begin
      if (window_size == '0) begin
         window_eff = WSIZE_W'(1);
      end else if (window_size > WSIZE_W'(WINDOW_MAX)) begin
         window_eff = WSIZE_W'(WINDOW_MAX);
      end else begin
         window_eff = window_size;
      end
   end

   always_comb begin
      if (restart_ff) begin
         seen_clamped = '0;
      end else if (seen_ff > window_eff) begin
         seen_clamped = window_eff;
      end else begin
         seen_clamped = seen_ff;
      end
      seen_next  = (seen_clamped < window_eff) ? WSIZE_W'(seen_clamped + 1'b1) : seen_clamped;
      has_result = (seen_next >= window_eff);
   end

   // Two stale slots at the front mean the window shrank: while an item is pending, retire one per cycle first.
   assign double_stale = stale[0] && stale[1];
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign fire_drop    = busy_ff && double_stale;
   assign fire_step    = busy_ff && !double_stale && (out_free || !has_result);
   assign req_ready    = !busy_ff || fire_step;
   assign req_fire     = req_valid && req_ready;

   always_comb begin
      ctrl.restart   = restart_ff;
      ctrl.sample    = sample_ff;
      ctrl.window    = window_eff;
      ctrl.shift_one = stale[0];
      if (fire_drop) begin
         ctrl.op = CELL_DROP;
      end else if (fire_step) begin
         ctrl.op = CELL_STEP;
      end else begin
         ctrl.op = CELL_HOLD;
      end
   end

   assign links[WINDOW_MAX] = '{live: 1'b0, value: '0, age: '0};
   assign keeps[0]          = 1'b1;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .position    (IDX_W'(i)),
         .next_link   (links[i+1]),
         .prev_keep   (keeps[i]),
         .link        (links[i]),
         .stale       (stale[i]),
         .keep        (keeps[i+1]),
         .front_value (front_values[i]),
         .valid       (valid_vec[i]),
         .age         (ages[i])
      );
   end

   always_comb begin
      busy_in    = busy_ff;
      sample_in  = sample_ff;
      restart_in = restart_ff;
      seen_in    = seen_ff;
      if (fire_step) begin
         busy_in = 1'b0;
         seen_in = seen_next;
      end
      if (req_fire) begin
         busy_in    = 1'b1;
         sample_in  = req_sample;
         restart_in = req_restart;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_max_in   = rsp_max_ff;
      if (fire_step && has_result) begin
         rsp_valid_in = 1'b1;
         rsp_max_in   = front_values[0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      restart_ff <= restart_in;
      rsp_max_ff <= rsp_max_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_max = rsp_max_ff;

   // Occupied slots always form a contiguous run starting at the front.
   a_queue_packed: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + 1'b1)) == '0)
      else $error("candidate queue has a hole");

   // When a second candidate is held, the front slot is older than it.
   a_ages_ordered: assert property (@(posedge clock) disable iff (reset)
      valid_vec[1] |-> (ages[0] > ages[1]))
      else $error("candidate ages out of order");

   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= WSIZE_W'(WINDOW_MAX))
      else $error("sample count above queue depth");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire_step && has_result))
      else $error("result raised without a processing step");

   a_drop_keeps_item: assert property (@(posedge clock) disable iff (reset)
      fire_drop |=> busy_ff)
      else $error("item lost during stale candidate retirement");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the sliding window maximum filter.
`timescale 1ns / 1ps

module tb;
   import swm_pkg::*;

   localparam int HALF_PERIOD    = 6;
   localparam int SETTLE_CYCLES  = 80;
   localparam int STALL_LIMIT    = 2000;
   localparam int HOLDOFF_CYCLES = 200;
   localparam int PHASE_ITEMS    = 110;
   localparam int PHASES         = 12;

   localparam logic [CSR_ADDR_W-1:0] WINDOW_SIZE_ADDR = CSR_ADDR_W'(4 * REG_WINDOW_SIZE);
   localparam logic signed [SAMPLE_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [SAMPLE_W-1:0] MOST_POSITIVE = 32'sh7fff_ffff;

   typedef enum int {
      STYLE_RANDOM,
      STYLE_FALLING,
      STYLE_NARROW,
      STYLE_CORNER
   } sample_style_type;

   // Running model of the filter plus the results it still owes.
   class window_max_board_type;
      logic [WSIZE_W-1:0]          window_size;
      logic signed [SAMPLE_W-1:0]  cand_value [WINDOW_MAX];
      int unsigned                 cand_age [WINDOW_MAX];
      int unsigned                 cand_count;
      int unsigned                 seen_count;
      logic signed [SAMPLE_W-1:0]  expected_max [$];
      int unsigned                 mismatches;

      function new();
         window_size = 1;
         cand_count  = 0;
         seen_count  = 0;
         mismatches  = 0;
      endfunction

      function int unsigned span();
         if (window_size == 0) return 1;
         if (window_size > WINDOW_MAX) return WINDOW_MAX;
         return window_size;
      endfunction

      function void retire_oldest();
         int unsigned i;
         for (i = 0; i + 1 < cand_count; i++) begin
            cand_value[i] = cand_value[i+1];
            cand_age[i]   = cand_age[i+1];
         end
         cand_count--;
      endfunction

      function void set_window(input logic [WSIZE_W-1:0] w);
         window_size = w;
      endfunction

      function void note_sample(input logic signed [SAMPLE_W-1:0] smp, input logic fresh);
         int unsigned w;
         int unsigned i;
         w = span();
         if (fresh) begin
            cand_count = 0;
            seen_count = 0;
         end
         // A shrunken window clips the queue and the count before this sample.
         if (cand_count > w) cand_count = w;
         if (seen_count > w) seen_count = w;
         for (i = 0; i < cand_count; i++) cand_age[i]++;
         while (cand_count > 0 && cand_age[0] >= w) retire_oldest();
         while (cand_count > 0 && smp > cand_value[cand_count-1]) cand_count--;
         if (cand_count >= WINDOW_MAX) retire_oldest();
         cand_value[cand_count] = smp;
         cand_age[cand_count]   = 0;
         cand_count++;
         if (seen_count < w) seen_count++;
         if (seen_count >= w) expected_max = {expected_max, cand_value[0]};
      endfunction

      function void check_max(input logic signed [SAMPLE_W-1:0] got);
         logic signed [SAMPLE_W-1:0] want;
         if (expected_max.size() == 0) begin
            $display("%0t: window_max expected none, got %0d", $time, got);
            mismatches++;
         end else begin
            want = expected_max[0];
            expected_max.delete(0);
            if (got !== want) begin
               $display("%0t: window_max expected %0d, got %0d", $time, want, got);
               mismatches++;
            end
         end
      endfunction

      function void check_window(input logic [WSIZE_W-1:0] got);
         if (got !== window_size) begin
            $display("%0t: window_size read expected %0d, got %0d", $time, window_size, got);
            mismatches++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_W-1:0]    req_sample = '0;
   logic                          req_restart = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0]    rsp_window_max;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]         csr_paddr = '0;
   logic [CSR_DATA_W-1:0]         csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]         csr_prdata;
   logic                          csr_pready;

   window_max_board_type          board = new();
   int                            send_idle_pct = 0;
   int                            recv_stall_pct = 0;
   int                            holdoff_request = 0;
   int                            holdoff_left = 0;
   int                            quiet_cycles = 0;
   logic signed [SAMPLE_W-1:0]    falling_level = '0;

   int               phase_window [PHASES]  = '{64, 64, 1, 3, 16, 0, 127, 5, 33, 2, 64, 7};
   bit               phase_restart [PHASES] = '{1, 0, 0, 1, 0, 1, 1, 0, 1, 1, 1, 0};
   sample_style_type phase_style [PHASES]   = '{STYLE_RANDOM, STYLE_FALLING, STYLE_RANDOM,
                                                STYLE_NARROW, STYLE_NARROW, STYLE_RANDOM,
                                                STYLE_FALLING, STYLE_RANDOM, STYLE_NARROW,
                                                STYLE_CORNER, STYLE_RANDOM, STYLE_FALLING};

   sliding_window_maximum dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_window_max (rsp_window_max),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // Result side: check each transaction, then pick the next ready level.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_max(rsp_window_max);
      if (holdoff_request > 0) begin
         holdoff_left    = holdoff_request;
         holdoff_request = 0;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL sliding_window_maximum");
            $finish;
         end
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] next_sample(input sample_style_type style);
      case (style)
         STYLE_FALLING: begin
            falling_level = falling_level - SAMPLE_W'($urandom_range(0, 2));
            return falling_level;
         end
         STYLE_NARROW: return SAMPLE_W'($urandom_range(0, 8)) - SAMPLE_W'(4);
         STYLE_CORNER: begin
            case ($urandom_range(0, 7))
               0: return MOST_NEGATIVE;
               1: return MOST_POSITIVE;
               2: return 0;
               3: return -1;
               4: return 1;
               5: return MOST_NEGATIVE + 1;
               6: return MOST_POSITIVE - 1;
               default: return $urandom();
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   // Called at a clock edge; returns at the edge where the transaction is taken.
   task automatic push_sample(input logic signed [SAMPLE_W-1:0] smp, input logic fresh);
      int gap;
      gap = 0;
      while (send_idle_pct > 0 && gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_sample  <= smp;
      req_restart <= fresh;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_sample(smp, fresh);
   endtask

   // Wait for every owed result, then let a sample that yields none drain out.
   task automatic settle();
      req_valid <= 1'b0;
      while (board.expected_max.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic read_window_size();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= WINDOW_SIZE_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.check_window(csr_prdata[WSIZE_W-1:0]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_window_size(input logic [WSIZE_W-1:0] w);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= WINDOW_SIZE_ADDR;
      csr_pwdata  <= ($urandom() & ~32'h7f) | CSR_DATA_W'(w);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.set_window(w);
      // Next cycle is the setup cycle of the read-back.
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.check_window(csr_prdata[WSIZE_W-1:0]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      int unsigned phase;
      int unsigned n;
      logic        fresh;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      read_window_size();

      // Window of one after reset: every sample is its own maximum.
      push_sample(MOST_NEGATIVE, 1'b1);
      push_sample(MOST_POSITIVE, 1'b0);
      push_sample(0, 1'b0);
      push_sample(-1, 1'b0);
      settle();
      set_window_size(4);
      // A sequence shorter than the window gives nothing.
      push_sample(10, 1'b1);
      push_sample(20, 1'b0);
      // Equal samples, and a large peak that must age out of the window.
      push_sample(5, 1'b1);
      push_sample(5, 1'b0);
      push_sample(3, 1'b0);
      push_sample(-7, 1'b0);
      push_sample(MOST_POSITIVE, 1'b0);
      push_sample(MOST_NEGATIVE, 1'b0);
      push_sample(MOST_NEGATIVE, 1'b0);
      push_sample(MOST_NEGATIVE, 1'b0);
      push_sample(MOST_NEGATIVE, 1'b0);
      settle();
      set_window_size(2);
      push_sample(-9, 1'b0);
      push_sample(-8, 1'b0);
      settle();
      set_window_size(6);
      push_sample(100, 1'b0);
      push_sample(-100, 1'b0);
      settle();
      // Zero acts as one, and anything past the maximum depth is clamped.
      set_window_size(0);
      push_sample(7, 1'b1);
      push_sample(8, 1'b0);
      settle();
      set_window_size(127);
      push_sample(1, 1'b1);
      push_sample(2, 1'b0);

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         settle();
         set_window_size(WSIZE_W'(phase_window[phase]));
         // Long receiver hold-off while the sender keeps offering at full rate.
         if (phase == 4) holdoff_request = HOLDOFF_CYCLES;
         falling_level = MOST_POSITIVE - SAMPLE_W'($urandom_range(0, 1000));
         for (n = 0; n < PHASE_ITEMS; n++) begin
            fresh = (n == 0 && phase_restart[phase]) || ($urandom_range(99) == 0);
            push_sample(next_sample(phase_style[phase]), fresh);
         end
      end

      settle();
      if (board.mismatches == 0 && board.expected_max.size() == 0) begin
         $display("PASS sliding_window_maximum");
      end else begin
         $display("FAIL sliding_window_maximum");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/swm_pkg.sv
design/swm_cell.sv
design/swm_csr.sv
design/sliding_window_maximum.sv
dv/tb.sv
